[rtl/camm_pkg.sv]
package camm_pkg;

	localparam int DATA_W = 24;
	localparam int IDX_W  = 3;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [1:0]               mode_t;

	localparam mode_t MODE_ASSIGN = 2'd0;
	localparam mode_t MODE_ADD    = 2'd1;
	localparam mode_t MODE_SUB    = 2'd2;

	localparam data_t DATA_MAX = 24'sh7FFFFF;
	localparam data_t DATA_MIN = 24'sh800000;

	// controller to datapath
	typedef struct packed {
		logic wr_en;      // store one loaded word
		logic load_last;  // final word of a set, latch the mode
		logic rd_en;      // one multiply-accumulate step
		logic first;      // first step of an element
		logic last;       // last step of an element
		idx_t row;
		idx_t col;
		logic final_elem; // element at the bottom right corner
	} camm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;       // a step is still in the pipeline
		logic out_busy;   // output register holds a word not taken this cycle
	} camm_sts_t;

endpackage

[rtl/camm_if.sv]
interface camm_in_if;
	import camm_pkg::*;
	logic  valid;
	logic  ready;
	data_t a_re;
	data_t a_im;
	data_t b_re;
	data_t b_im;
	data_t c_re;
	data_t c_im;
	modport source(output valid, a_re, a_im, b_re, b_im, c_re, c_im, input ready);
	modport sink(input valid, a_re, a_im, b_re, b_im, c_re, c_im, output ready);
endinterface

interface camm_out_if;
	import camm_pkg::*;
	logic  valid;
	logic  ready;
	data_t out_re;
	data_t out_im;
	idx_t  row;
	idx_t  col;
	logic  saturated;
	logic  last;
	modport source(output valid, out_re, out_im, row, col, saturated, last, input ready);
	modport sink(input valid, out_re, out_im, row, col, saturated, last, output ready);
endinterface

interface camm_cfg_if;
	import camm_pkg::*;
	logic  valid;
	logic  ready;
	mode_t mode;
	modport source(output valid, mode, input ready);
	modport sink(input valid, mode, output ready);
endinterface

[rtl/camm_ctrl.sv]
module camm_ctrl #(
	parameter int DIM = 3,
	localparam int NE = DIM * DIM,
	localparam int AW = (NE > 1) ? $clog2(NE) : 1,
	localparam int IW = (DIM > 1) ? $clog2(DIM) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  camm_pkg::camm_sts_t sts,
	output camm_pkg::camm_cmd_t cmd,
	output logic [AW-1:0]       wr_addr,
	output logic [AW-1:0]       a_rd_addr,
	output logic [AW-1:0]       b_rd_addr,
	output logic [AW-1:0]       c_rd_addr
);
	import camm_pkg::*;

	typedef enum logic [1:0] {
		S_LOAD,
		S_RUN,
		S_WAIT
	} state_t;

	state_t        state_q;
	logic [AW-1:0] ld_q;
	logic [AW-1:0] a_addr_q;
	logic [AW-1:0] b_addr_q;
	logic [AW-1:0] c_addr_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] k_q;
	logic          accept;
	logic          final_elem;

	assign in_ready   = (state_q == S_LOAD);
	assign accept     = in_valid && in_ready;
	assign final_elem = (i_q == IW'(DIM - 1)) && (j_q == IW'(DIM - 1));

	assign wr_addr   = ld_q;
	assign a_rd_addr = a_addr_q;
	assign b_rd_addr = b_addr_q;
	assign c_rd_addr = c_addr_q;

	always_comb begin
		cmd            = '0;
		cmd.wr_en      = accept;
		cmd.load_last  = accept && (ld_q == AW'(NE - 1));
		cmd.rd_en      = (state_q == S_RUN);
		cmd.first      = (k_q == '0);
		cmd.last       = (k_q == IW'(DIM - 1));
		cmd.row        = IDX_W'(i_q);
		cmd.col        = IDX_W'(j_q);
		cmd.final_elem = final_elem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			ld_q     <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
			c_addr_q <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (ld_q == AW'(NE - 1)) begin
							ld_q     <= '0;
							i_q      <= '0;
							j_q      <= '0;
							k_q      <= '0;
							a_addr_q <= '0;
							b_addr_q <= '0;
							c_addr_q <= '0;
							state_q  <= S_RUN;
						end else begin
							ld_q <= ld_q + AW'(1);
						end
					end
				end
				S_RUN: begin
					// walk down column i of A and column j of B
					a_addr_q <= a_addr_q + AW'(DIM);
					b_addr_q <= b_addr_q + AW'(DIM);
					if (k_q == IW'(DIM - 1)) begin
						k_q     <= '0;
						state_q <= S_WAIT;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				S_WAIT: begin
					if (final_elem) begin
						// final word must leave before the next set can overwrite it
						if (!sts.busy && !sts.out_busy) begin
							state_q <= S_LOAD;
						end
					end else if (!sts.busy && !sts.out_busy) begin
						c_addr_q <= c_addr_q + AW'(1);
						if (j_q == IW'(DIM - 1)) begin
							j_q      <= '0;
							i_q      <= i_q + IW'(1);
							a_addr_q <= AW'(i_q + IW'(1));
							b_addr_q <= '0;
						end else begin
							j_q      <= j_q + IW'(1);
							a_addr_q <= AW'(i_q);
							b_addr_q <= AW'(j_q + IW'(1));
						end
						state_q <= S_RUN;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

[rtl/camm_datapath.sv]
module camm_datapath #(
	parameter int DIM = 3,
	parameter int FRAC_BITS = 16,
	localparam int NE = DIM * DIM,
	localparam int AW = (NE > 1) ? $clog2(NE) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  camm_pkg::camm_cmd_t cmd,
	output camm_pkg::camm_sts_t sts,
	input  logic [AW-1:0]       wr_addr,
	input  logic [AW-1:0]       a_rd_addr,
	input  logic [AW-1:0]       b_rd_addr,
	input  logic [AW-1:0]       c_rd_addr,
	input  logic                cfg_wr,
	input  camm_pkg::mode_t     cfg_mode,
	input  camm_pkg::data_t     a_re,
	input  camm_pkg::data_t     a_im,
	input  camm_pkg::data_t     b_re,
	input  camm_pkg::data_t     b_im,
	input  camm_pkg::data_t     c_re,
	input  camm_pkg::data_t     c_im,
	output logic                out_valid,
	input  logic                out_ready,
	output camm_pkg::data_t     out_re,
	output camm_pkg::data_t     out_im,
	output camm_pkg::idx_t      row,
	output camm_pkg::idx_t      col,
	output logic                saturated,
	output logic                last
);
	import camm_pkg::*;

	localparam int EW     = 2 * DATA_W;
	localparam int PW     = 2 * DATA_W;
	localparam int ACC_W  = PW + 1 + ((DIM > 1) ? $clog2(DIM) : 0);
	localparam int TW     = ACC_W + 1;
	localparam int RW     = TW + 1;
	localparam logic signed [RW-1:0] HALF = RW'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [RW-1:0] RMAX = RW'(DATA_MAX);
	localparam logic signed [RW-1:0] RMIN = RW'(DATA_MIN);

	logic [EW-1:0] a_mem [NE];
	logic [EW-1:0] b_mem [NE];
	logic [EW-1:0] c_mem [NE];

	mode_t mode_q;
	mode_t run_mode_q;

	// stage 1: registered store reads
	logic [EW-1:0] a_rd_s1, b_rd_s1, c_rd_s1;
	logic          v_s1, first_s1, last_s1;
	data_t         ar_s1, ai_s1, br_s1, bi_s1;

	// stage 2: four partial products
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic [EW-1:0]        c_s2;
	logic                 v_s2, first_s2, last_s2;
	logic signed [PW:0]   term_re, term_im;

	// stage 3: accumulators
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic [EW-1:0]           c_s3;
	logic                    done_s3;
	data_t                   cr_s3, ci_s3;
	logic signed [TW-1:0]    cs_re, cs_im, ac_re, ac_im, tot_re, tot_im;

	// stage 4: mode applied
	logic signed [TW-1:0] tot_re_s4, tot_im_s4;
	logic                 done_s4;
	logic signed [RW-1:0] rnd_re, rnd_im;
	logic                 clip_re, clip_im;
	data_t                res_re, res_im;

	// output register
	logic  out_valid_q;
	data_t out_re_q, out_im_q;
	idx_t  row_q, col_q;
	logic  sat_q, last_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			a_mem[wr_addr] <= {a_re, a_im};
			b_mem[wr_addr] <= {b_re, b_im};
			c_mem[wr_addr] <= {c_re, c_im};
		end
		if (cmd.rd_en) begin
			a_rd_s1 <= a_mem[a_rd_addr];
			b_rd_s1 <= b_mem[b_rd_addr];
			c_rd_s1 <= c_mem[c_rd_addr];
		end
	end

	assign ar_s1 = a_rd_s1[EW-1:DATA_W];
	assign ai_s1 = a_rd_s1[DATA_W-1:0];
	assign br_s1 = b_rd_s1[EW-1:DATA_W];
	assign bi_s1 = b_rd_s1[DATA_W-1:0];

	// conj(a) * b
	assign term_re = (PW+1)'(p_rr_s2) + (PW+1)'(p_ii_s2);
	assign term_im = (PW+1)'(p_ri_s2) - (PW+1)'(p_ir_s2);

	assign cr_s3 = c_s3[EW-1:DATA_W];
	assign ci_s3 = c_s3[DATA_W-1:0];
	assign cs_re = TW'(cr_s3) <<< FRAC_BITS;
	assign cs_im = TW'(ci_s3) <<< FRAC_BITS;
	assign ac_re = TW'(acc_re_q);
	assign ac_im = TW'(acc_im_q);

	always_comb begin
		unique case (run_mode_q)
			MODE_ADD: begin
				tot_re = cs_re + ac_re;
				tot_im = cs_im + ac_im;
			end
			MODE_SUB: begin
				tot_re = cs_re - ac_re;
				tot_im = cs_im - ac_im;
			end
			default: begin
				tot_re = ac_re;
				tot_im = ac_im;
			end
		endcase
	end

	// round half up, then clip to 24 bits
	assign rnd_re  = (RW'(tot_re_s4) + HALF) >>> FRAC_BITS;
	assign rnd_im  = (RW'(tot_im_s4) + HALF) >>> FRAC_BITS;
	assign clip_re = (rnd_re > RMAX) || (rnd_re < RMIN);
	assign clip_im = (rnd_im > RMAX) || (rnd_im < RMIN);
	assign res_re  = (rnd_re > RMAX) ? DATA_MAX :
	                 (rnd_re < RMIN) ? DATA_MIN : rnd_re[DATA_W-1:0];
	assign res_im  = (rnd_im > RMAX) ? DATA_MAX :
	                 (rnd_im < RMIN) ? DATA_MIN : rnd_im[DATA_W-1:0];

	always_ff @(posedge clk) begin
		if (v_s1) begin
			p_rr_s2 <= ar_s1 * br_s1;
			p_ii_s2 <= ai_s1 * bi_s1;
			p_ri_s2 <= ar_s1 * bi_s1;
			p_ir_s2 <= ai_s1 * br_s1;
			c_s2    <= c_rd_s1;
		end
		if (v_s2) begin
			acc_re_q <= first_s2 ? ACC_W'(term_re) : acc_re_q + ACC_W'(term_re);
			acc_im_q <= first_s2 ? ACC_W'(term_im) : acc_im_q + ACC_W'(term_im);
			c_s3     <= c_s2;
		end
		if (done_s3) begin
			tot_re_s4 <= tot_re;
			tot_im_s4 <= tot_im;
		end
		if (done_s4) begin
			out_re_q <= res_re;
			out_im_q <= res_im;
			sat_q    <= clip_re || clip_im;
			row_q    <= cmd.row;
			col_q    <= cmd.col;
			last_q   <= cmd.final_elem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ASSIGN;
			run_mode_q  <= MODE_ASSIGN;
			v_s1        <= 1'b0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
			v_s2        <= 1'b0;
			first_s2    <= 1'b0;
			last_s2     <= 1'b0;
			done_s3     <= 1'b0;
			done_s4     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				mode_q <= cfg_mode;
			end
			if (cmd.load_last) begin
				run_mode_q <= mode_q;
			end
			v_s1     <= cmd.rd_en;
			first_s1 <= cmd.first;
			last_s1  <= cmd.last;
			v_s2     <= v_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			done_s3  <= v_s2 && last_s2;
			done_s4  <= done_s3;
			if (done_s4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.busy     = v_s1 || v_s2 || done_s3 || done_s4;
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign row       = row_q;
	assign col       = col_q;
	assign saturated = sat_q;
	assign last      = last_q;

endmodule

[rtl/complex_adjoint_matrix_multiply_core.sv]
// channel | dir | handshake   | payload
// cfg     | in  | valid/ready | mode (2 bits): 0 assign, 1 c + p, 2 c - p, 3 acts as assign
// din     | in  | valid/ready | a_re a_im b_re b_im c_re c_im, 24-bit signed fixed point
// dout    | out | valid/ready | out_re out_im row col saturated last
//
// a set is DIM*DIM input words, one cycle each, then DIM*DIM result words
// each result element is summed over k on the one complex multiply-accumulate
// unit, and the pipeline drains before the next element starts
// arst_n clears the controller, the mode register and the pipeline valids
// a stalled dout holds the next element back; the next set loads only once
// the final result word has been taken
module complex_adjoint_matrix_multiply_core #(
	parameter int DIM = 3,
	parameter int FRAC_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	camm_cfg_if.sink   cfg,
	camm_in_if.sink    din,
	camm_out_if.source dout
);
	import camm_pkg::*;

	localparam int NE = DIM * DIM;
	localparam int AW = (NE > 1) ? $clog2(NE) : 1;

	camm_cmd_t     cmd;
	camm_sts_t     sts;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] a_rd_addr;
	logic [AW-1:0] b_rd_addr;
	logic [AW-1:0] c_rd_addr;

	// the mode register takes a word at any time
	assign cfg.ready = 1'b1;

	// sequencing: load count, element walk and k loop
	camm_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.sts      (sts),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.a_rd_addr(a_rd_addr),
		.b_rd_addr(b_rd_addr),
		.c_rd_addr(c_rd_addr)
	);

	// matrix stores, multiply-accumulate pipeline, round and clip, output word
	camm_datapath #(
		.DIM      (DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.wr_addr  (wr_addr),
		.a_rd_addr(a_rd_addr),
		.b_rd_addr(b_rd_addr),
		.c_rd_addr(c_rd_addr),
		.cfg_wr   (cfg.valid && cfg.ready),
		.cfg_mode (cfg.mode),
		.a_re     (din.a_re),
		.a_im     (din.a_im),
		.b_re     (din.b_re),
		.b_im     (din.b_im),
		.c_re     (din.c_re),
		.c_im     (din.c_im),
		.out_valid(dout.valid),
		.out_ready(dout.ready),
		.out_re   (dout.out_re),
		.out_im   (dout.out_im),
		.row      (dout.row),
		.col      (dout.col),
		.saturated(dout.saturated),
		.last     (dout.last)
	);

endmodule

[rtl/camm_chk.sv]
module camm_chk #(
	parameter int DIM = 3
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  out_last,
	input camm_pkg::data_t       out_re,
	input camm_pkg::idx_t        out_row,
	input camm_pkg::idx_t        out_col
);
	import camm_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_row))
		else $error("result word changed while stalled");

	// input is not ready while a result word other than the final one is on dout
	a_no_load_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input ready during result emission");

	// the final word sits at the bottom right corner
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |->
		(out_row == IDX_W'(DIM - 1)) && (out_col == IDX_W'(DIM - 1)))
		else $error("last flag on wrong element");

	// once the final word is taken, dout valid drops
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("result word right after the final one");

	// the input side is never ready and handed a word while a result waits mid-set
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !(out_valid && !out_last))
		else $error("input taken during result emission");

endmodule

bind complex_adjoint_matrix_multiply_core camm_chk #(
	.DIM(DIM)
) u_camm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (din.valid),
	.in_ready (din.ready),
	.out_valid(dout.valid),
	.out_ready(dout.ready),
	.out_last (dout.last),
	.out_re   (dout.out_re),
	.out_row  (dout.row),
	.out_col  (dout.col)
);

[tb/testbench.sv]
module testbench;
	import camm_pkg::*;

	localparam int DIM            = 3;
	localparam int FRAC_BITS      = 16;
	localparam int NELEM          = DIM * DIM;
	// idle time in clock cycles before a mode write
	localparam int SETTLE         = 4 * (DIM + 6);
	localparam int DRAIN          = 100;
	localparam int PHASES         = 9;
	localparam int SETS_PER_PHASE = 3;
	localparam int MAX_REPORTS    = 10;
	localparam int DIR_ROWS       = 6;

	// spare encoding of the mode register, the block treats it as assign
	localparam mode_t MODE_SPARE = 2'd3;

	// one input word: an element of each of a, b and c
	typedef struct packed {
		data_t a_re;
		data_t a_im;
		data_t b_re;
		data_t b_im;
		data_t c_re;
		data_t c_im;
	} word_t;

	// one result element as it should leave dout
	typedef struct packed {
		data_t re;
		data_t im;
		idx_t  row;
		idx_t  col;
		logic  sat;
		logic  last;
	} elem_t;

	// directed row: optional mode write, then the same word reps times
	// when typed is set, e_* is the value of every element of the set closed by this row
	typedef struct packed {
		logic       wr_mode;
		mode_t      mode;
		logic [7:0] reps;
		word_t      w;
		logic       typed;
		data_t      e_re;
		data_t      e_im;
		logic       e_sat;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// rounding ties: conj(1) * 0.5 lsb goes up, conj(-1) * 0.5 lsb goes to zero
		// c is full scale but must be ignored in assign mode
		'{1'b1, MODE_ASSIGN, 8'd1,
			'{24'sd1, 24'sd0, 24'sd32768, 24'sd0, DATA_MAX, DATA_MIN},
			1'b0, 24'sd0, 24'sd0, 1'b0},
		'{1'b0, MODE_ASSIGN, 8'd3,
			'{24'sd0, 24'sd0, 24'sd0, 24'sd0, DATA_MAX, DATA_MIN},
			1'b0, 24'sd0, 24'sd0, 1'b0},
		'{1'b0, MODE_ASSIGN, 8'd1,
			'{-24'sd1, 24'sd0, 24'sd32768, 24'sd0, DATA_MIN, DATA_MAX},
			1'b0, 24'sd0, 24'sd0, 1'b0},
		'{1'b0, MODE_ASSIGN, 8'd4,
			'{24'sd0, 24'sd0, 24'sd0, 24'sd0, DATA_MIN, DATA_MAX},
			1'b0, 24'sd0, 24'sd0, 1'b0},
		// most negative a, b and real c, add: real part clips high, imag is just c
		'{1'b1, MODE_ADD, 8'd9,
			'{DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX},
			1'b1, DATA_MAX, DATA_MAX, 1'b1},
		// mixed extremes, subtract from zero c
		'{1'b1, MODE_SUB, 8'd9,
			'{DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX, 24'sd0, 24'sd0},
			1'b0, 24'sd0, 24'sd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	camm_cfg_if cfg_if ();
	camm_in_if  din_if ();
	camm_out_if dout_if ();

	complex_adjoint_matrix_multiply_core #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.din    (din_if),
		.dout   (dout_if)
	);

	// 2 time unit period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// our own copy of the three matrix stores, fill level and mode
	data_t a_re_st [NELEM];
	data_t a_im_st [NELEM];
	data_t b_re_st [NELEM];
	data_t b_im_st [NELEM];
	data_t c_re_st [NELEM];
	data_t c_im_st [NELEM];
	int unsigned fill;
	mode_t       mode_seen;

	// result elements still owed by the block, oldest first
	elem_t exp_elems [$];

	// hand-typed value attached to the word currently on din
	logic  cur_typed;
	data_t cur_e_re;
	data_t cur_e_im;
	logic  cur_e_sat;

	// phases with no idling on the sender or the receiver side
	logic snd_burst;
	logic rcv_burst;

	int unsigned fail_cnt;
	int unsigned n_words;
	int unsigned n_elems;
	int unsigned n_sat;
	int unsigned n_sets;
	logic [3:0]  modes_hit;

	// round half up at the fraction point, then clip to 24 bits
	// returns {clipped, value}
	function automatic logic [DATA_W:0] round_sat(longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (q > longint'(DATA_MAX))
			return {1'b1, DATA_MAX};
		if (q < longint'(DATA_MIN))
			return {1'b1, DATA_MIN};
		return {1'b0, q[DATA_W-1:0]};
	endfunction

	// store one accepted word; on a set's last word work out, for every element,
	// conj(a)^t * b, or c +/- it in add and sub modes, queued in row-major order
	task automatic absorb_word(word_t w);
		int i;
		int j;
		int k;
		longint sre;
		longint sim;
		longint ar;
		longint ai;
		longint br;
		longint bi;
		longint scale;
		logic [DATA_W:0] rr;
		logic [DATA_W:0] ri;
		elem_t e;
		a_re_st[fill] = w.a_re;
		a_im_st[fill] = w.a_im;
		b_re_st[fill] = w.b_re;
		b_im_st[fill] = w.b_im;
		c_re_st[fill] = w.c_re;
		c_im_st[fill] = w.c_im;
		fill++;
		if (fill < NELEM)
			return;
		fill = 0;
		n_sets++;
		modes_hit[mode_seen] = 1'b1;
		scale = longint'(1) <<< FRAC_BITS;
		for (i = 0; i < DIM; i++) begin
			for (j = 0; j < DIM; j++) begin
				sre = 0;
				sim = 0;
				// column i of a, conjugated, against column j of b
				for (k = 0; k < DIM; k++) begin
					ar = a_re_st[k*DIM + i];
					ai = a_im_st[k*DIM + i];
					br = b_re_st[k*DIM + j];
					bi = b_im_st[k*DIM + j];
					sre += ar * br + ai * bi;
					sim += ar * bi - ai * br;
				end
				// c is lifted to the product scale before the single rounding
				if (mode_seen == MODE_ADD) begin
					sre = longint'(c_re_st[i*DIM + j]) * scale + sre;
					sim = longint'(c_im_st[i*DIM + j]) * scale + sim;
				end else if (mode_seen == MODE_SUB) begin
					sre = longint'(c_re_st[i*DIM + j]) * scale - sre;
					sim = longint'(c_im_st[i*DIM + j]) * scale - sim;
				end
				rr = round_sat(sre);
				ri = round_sat(sim);
				e.re   = rr[DATA_W-1:0];
				e.im   = ri[DATA_W-1:0];
				e.row  = idx_t'(i);
				e.col  = idx_t'(j);
				e.sat  = rr[DATA_W] | ri[DATA_W];
				e.last = (i == DIM - 1) && (j == DIM - 1);
				// directed rows with a typed answer take it in place of ours
				if (cur_typed) begin
					e.re  = cur_e_re;
					e.im  = cur_e_im;
					e.sat = cur_e_sat;
				end
				exp_elems.push_back(e);
			end
		end
	endtask

	// compare one taken result word with the oldest one owed
	task automatic check_elem();
		elem_t got;
		elem_t want;
		got.re   = dout_if.out_re;
		got.im   = dout_if.out_im;
		got.row  = dout_if.row;
		got.col  = dout_if.col;
		got.sat  = dout_if.saturated;
		got.last = dout_if.last;
		n_elems++;
		if (got.sat === 1'b1)
			n_sat++;
		if (exp_elems.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= MAX_REPORTS)
				$display("unexpected result word: row %0d col %0d re %0d im %0d",
					got.row, got.col, got.re, got.im);
			return;
		end
		want = exp_elems.pop_front();
		if (got !== want) begin
			fail_cnt++;
			if (fail_cnt <= MAX_REPORTS) begin
				$display("mismatch: expected (%0d,%0d) re %0d im %0d sat %0b last %0b",
					want.row, want.col, want.re, want.im, want.sat, want.last);
				$display("          got      (%0d,%0d) re %0d im %0d sat %0b last %0b",
					got.row, got.col, got.re, got.im, got.sat, got.last);
			end
		end
	endtask

	// all three channels are observed at the rising edge, with the values
	// that were driven at the falling edge before it
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				mode_seen = cfg_if.mode;
			if (din_if.valid && din_if.ready) begin
				absorb_word('{din_if.a_re, din_if.a_im, din_if.b_re,
					din_if.b_im, din_if.c_re, din_if.c_im});
			end
			if (dout_if.valid && dout_if.ready)
				check_elem();
		end
	end

	// random value scaled down by an arithmetic shift, now and then an extreme or zero
	function automatic data_t draw_val(int unsigned sh);
		logic [31:0] r;
		data_t v;
		r = $urandom;
		case ($urandom_range(0, 15))
			0: begin
				return DATA_MAX;
			end
			1: begin
				return DATA_MIN;
			end
			2: begin
				return '0;
			end
			default: ;
		endcase
		v = data_t'(r[DATA_W-1:0]);
		return v >>> sh;
	endfunction

	// offer one word on din after a random gap, none in burst phases; valid
	// stays high after acceptance so that a zero gap gives back-to-back words
	task automatic send_word(word_t w, logic typed, data_t e_re, data_t e_im, logic e_sat);
		int unsigned gap;
		gap = snd_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_typed = typed;
		cur_e_re  = e_re;
		cur_e_im  = e_im;
		cur_e_sat = e_sat;
		din_if.valid <= 1'b1;
		din_if.a_re  <= w.a_re;
		din_if.a_im  <= w.a_im;
		din_if.b_re  <= w.b_re;
		din_if.b_im  <= w.b_im;
		din_if.c_re  <= w.c_re;
		din_if.c_im  <= w.c_im;
		do @(posedge clk); while (!din_if.ready);
		@(negedge clk);
		n_words++;
	endtask

	// mode writes only at a set boundary with every result drained
	task automatic set_mode(mode_t m);
		din_if.valid <= 1'b0;
		while (exp_elems.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.mode  <= m;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// result side: random stall before each word, none in burst phases
	initial begin
		int unsigned stall;
		dout_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = rcv_burst ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				dout_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			dout_if.ready <= 1'b1;
			do @(posedge clk); while (!dout_if.valid);
			@(negedge clk);
		end
	end

	// stimulus
	initial begin
		int unsigned r;
		int unsigned k;
		int unsigned p;
		int unsigned s;
		int unsigned sh_ab;
		int unsigned sh_c;
		mode_t m;
		word_t w;
		arst_n       = 1'b0;
		din_if.valid = 1'b0;
		din_if.a_re  = '0;
		din_if.a_im  = '0;
		din_if.b_re  = '0;
		din_if.b_im  = '0;
		din_if.c_re  = '0;
		din_if.c_im  = '0;
		cfg_if.valid = 1'b0;
		cfg_if.mode  = MODE_ASSIGN;
		snd_burst    = 1'b0;
		rcv_burst    = 1'b0;
		cur_typed    = 1'b0;
		cur_e_re     = '0;
		cur_e_im     = '0;
		cur_e_sat    = 1'b0;
		fill         = 0;
		mode_seen    = MODE_ASSIGN;
		fail_cnt     = 0;
		n_words      = 0;
		n_elems      = 0;
		n_sat        = 0;
		n_sets       = 0;
		modes_hit    = '0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table: a rounding tie pair, c ignored, saturation at the extremes
		for (r = 0; r < DIR_ROWS; r++) begin
			if (DIR_TAB[r].wr_mode)
				set_mode(DIR_TAB[r].mode);
			for (k = 0; k < DIR_TAB[r].reps; k++)
				send_word(DIR_TAB[r].w, DIR_TAB[r].typed,
					DIR_TAB[r].e_re, DIR_TAB[r].e_im, DIR_TAB[r].e_sat);
		end

		// random phases: the first ones walk every mode encoding, the spare
		// one included, then the mode is drawn; sets in a phase run back to back
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					m = MODE_SPARE;
				end
				1: begin
					m = MODE_ADD;
				end
				2: begin
					m = MODE_ASSIGN;
				end
				3: begin
					m = MODE_SUB;
				end
				default: begin
					m = mode_t'($urandom_range(0, 3));
				end
			endcase
			set_mode(m);
			snd_burst = ($urandom_range(0, 3) == 0);
			rcv_burst = ($urandom_range(0, 3) == 0);
			for (s = 0; s < SETS_PER_PHASE; s++) begin
				// per-set magnitude: full scale mostly clips, large shifts mostly stay in range
				sh_ab = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 16);
				sh_c  = $urandom_range(0, 12);
				for (k = 0; k < NELEM; k++) begin
					w.a_re = draw_val(sh_ab);
					w.a_im = draw_val(sh_ab);
					w.b_re = draw_val(sh_ab);
					w.b_im = draw_val(sh_ab);
					w.c_re = draw_val(sh_c);
					w.c_im = draw_val(sh_c);
					send_word(w, 1'b0, '0, '0, 1'b0);
				end
			end
		end
		din_if.valid <= 1'b0;

		// let every owed element come out, then watch for strays
		while (exp_elems.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (exp_elems.size() != 0) begin
			fail_cnt += exp_elems.size();
			$display("%0d result words never arrived", exp_elems.size());
		end

		$display("ran %0d input words in %0d sets, took %0d result words, %0d of them clipped",
			n_words, n_sets, n_elems, n_sat);
		$display("mode encodings applied to sets (bit per encoding): %b, failures: %0d",
			modes_hit, fail_cnt);
		if (fail_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#400000;
		$display("timeout with %0d result words outstanding", exp_elems.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[complex_adjoint_matrix_multiply_core.f]
rtl/camm_pkg.sv
rtl/camm_if.sv
rtl/camm_ctrl.sv
rtl/camm_datapath.sv
rtl/complex_adjoint_matrix_multiply_core.sv
rtl/camm_chk.sv
tb/testbench.sv
